// ===== hdl/b64_pkg.sv =====
// Package: shared constants, group struct and symbol mapping for the Base64 encoder.
`default_nettype none
package b64_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] STD_CHAR62 = 8'h2B;  // '+'
  localparam logic [7:0] STD_CHAR63 = 8'h2F;  // '/'
  localparam logic [7:0] URL_CHAR62 = 8'h2D;  // '-'
  localparam logic [7:0] URL_CHAR63 = 8'h5F;  // '_'

  localparam int GRP_CHARS  = 4;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic                       valid;
    logic [GRP_CHARS-1:0][7:0]  chars;    // chars[0] goes out first
    logic [CNT_W-1:0]           count;    // 2..4
    logic                       msg_end;
  } b64_grp_t;

  function automatic logic [7:0] sym_to_char(input logic [5:0] v, input logic url);
    logic [7:0] v8;
    logic [7:0] ch;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      ch = 8'h41 + v8;
    end else if (v < 6'd52) begin
      ch = 8'h61 + (v8 - 8'd26);
    end else if (v < 6'd62) begin
      ch = 8'h30 + (v8 - 8'd52);
    end else if (v == 6'd62) begin
      ch = url ? URL_CHAR62 : STD_CHAR62;
    end else begin
      ch = url ? URL_CHAR63 : STD_CHAR63;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/b64_ifs.sv =====
// Interfaces: byte input, character output and configuration write channels.
`default_nettype none
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       message_end;
  modport source (output valid, output out_char, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input message_end,
                  output ready);
endinterface

interface b64_cfg_if;
  logic valid;
  logic ready;
  logic alphabet_mode;
  modport source (output valid, output alphabet_mode, input ready);
  modport sink   (input valid, input alphabet_mode, output ready);
endinterface
`default_nettype wire

// ===== hdl/base64_stream_encoder.sv =====
// Top level: streaming Base64 / base64url encoder with alphabet mode register.
//
//  channel   dir   word                                   accepted when
//  in_bus    in    data_byte[8], last_byte                valid && ready
//  out_bus   out   out_char[8], run_last, message_end     valid && ready
//  cfg_bus   in    alphabet_mode                          valid && ready (ready always 1)
//
//  A byte that closes a group loads 2 to 4 characters into the output register in the
//  cycle it is accepted; they leave one word per cycle while out_bus is ready, from
//  the next cycle. Held bytes are taken every cycle; a closing byte waits until the
//  output register is empty or sends its final word, so new bytes are taken while a
//  group leaves. Synchronous active-low reset clears group state, output count and mode.
`default_nettype none
module base64_stream_encoder (
  input  wire logic clk,
  input  wire logic rst_n,
  b64_in_if.sink    in_bus,
  b64_out_if.source out_bus,
  b64_cfg_if.sink   cfg_bus
);

  logic              mode_r, mode_nxt;
  logic              load_ready;
  b64_pkg::b64_grp_t grp;

  assign cfg_bus.ready = 1'b1;
  assign mode_nxt = (cfg_bus.valid && cfg_bus.ready) ? cfg_bus.alphabet_mode : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  b64_group u_group (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .mode       (mode_r),
    .load_ready (load_ready),
    .grp        (grp)
  );

  b64_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp        (grp),
    .load_ready (load_ready),
    .out_bus    (out_bus)
  );

`ifndef NO_ASSERTIONS
  // a loaded group shows up at the output next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    grp.valid && load_ready |=> out_bus.valid)
    else $error("loaded group not presented");

  // a closing byte is never accepted while the output register cannot load
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    grp.valid && !load_ready |-> !in_bus.ready)
    else $error("group accepted without room");

  // message end only on the last character of a run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.message_end |-> out_bus.run_last)
    else $error("message_end without run_last");
`endif

endmodule
`default_nettype wire

// ===== hdl/b64_group.sv =====
// Group collector: holds pending bytes and maps a closed group to its characters.
`default_nettype none
module b64_group (
  input  wire logic      clk,
  input  wire logic      rst_n,
  b64_in_if.sink         in_bus,
  input  wire logic      mode,
  input  wire logic      load_ready,
  output b64_pkg::b64_grp_t grp
);

  logic [7:0]  pend0_r, pend0_nxt;
  logic [7:0]  pend1_r, pend1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic        full;
  logic        emit;
  logic        accept;
  logic [7:0]  p0, p1, p2;
  logic [23:0] grp_word;
  logic [2:0]  nsym;
  logic [3:0][7:0] chars;

  assign full   = cnt_r[1];  // count 3 behaves like 2
  assign emit   = full || in_bus.last_byte;
  assign in_bus.ready = load_ready || !emit;
  assign accept = in_bus.valid && in_bus.ready;

  always_comb begin
    p0   = (cnt_r == 2'd0) ? in_bus.data_byte : pend0_r;
    p1   = (cnt_r == 2'd0) ? 8'd0 : ((cnt_r == 2'd1) ? in_bus.data_byte : pend1_r);
    p2   = full ? in_bus.data_byte : 8'd0;
    nsym = full ? 3'd4 : ((cnt_r == 2'd1) ? 3'd3 : 3'd2);
    grp_word = {p0, p1, p2};
    for (int k = 0; k < b64_pkg::GRP_CHARS; k++) begin
      if (3'(k) < nsym) begin
        chars[k] = b64_pkg::sym_to_char(grp_word[23 - 6*k -: 6], mode);
      end else begin
        chars[k] = b64_pkg::PAD_CHAR;
      end
    end
  end

  always_comb begin
    grp.valid   = in_bus.valid && emit;
    grp.chars   = chars;
    grp.count   = mode ? nsym : 3'd4;
    grp.msg_end = in_bus.last_byte;
  end

  always_comb begin
    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (emit) begin
        pend0_nxt = 8'd0;
        pend1_nxt = 8'd0;
        cnt_nxt   = 2'd0;
      end else if (cnt_r == 2'd0) begin
        pend0_nxt = in_bus.data_byte;
        cnt_nxt   = 2'd1;
      end else begin
        pend1_nxt = in_bus.data_byte;
        cnt_nxt   = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend0_r <= 8'd0;
      pend1_r <= 8'd0;
      cnt_r   <= 2'd0;
    end else begin
      pend0_r <= pend0_nxt;
      pend1_r <= pend1_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/b64_serializer.sv =====
// Serializer: result register; sends group chars one word per cycle when ready.
`default_nettype none
module b64_serializer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire b64_pkg::b64_grp_t grp,
  output logic              load_ready,
  b64_out_if.source         out_bus
);

  logic [3:0][7:0]            chars_r, chars_nxt;
  logic [b64_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       msg_r, msg_nxt;
  logic                       out_acc;
  logic                       load;

  assign out_acc    = out_bus.valid && out_bus.ready;
  assign load_ready = (cnt_r == '0) || ((cnt_r == 3'd1) && out_bus.ready);
  assign load       = grp.valid && load_ready;

  assign out_bus.valid       = (cnt_r != '0);
  assign out_bus.out_char    = chars_r[0];
  assign out_bus.run_last    = (cnt_r == 3'd1);
  assign out_bus.message_end = (cnt_r == 3'd1) && msg_r;

  always_comb begin
    chars_nxt = chars_r;
    cnt_nxt   = cnt_r;
    msg_nxt   = msg_r;
    if (load) begin
      chars_nxt = grp.chars;
      cnt_nxt   = grp.count;
      msg_nxt   = grp.msg_end;
    end else if (out_acc) begin
      chars_nxt = chars_r >> 8;
      cnt_nxt   = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
    msg_r   <= msg_nxt;
  end

endmodule
`default_nettype wire
